[rtl/core/column_sum_then_matvec_assert.svh]
// assertion macros shared by the column sum and matrix-vector product block
`ifndef COLUMN_SUM_THEN_MATVEC_ASSERT_SVH
`define COLUMN_SUM_THEN_MATVEC_ASSERT_SVH

// same-cycle implication, checked on every clock edge out of reset
`define CSMV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csmv assertion failed");

// next-cycle implication, checked on every clock edge out of reset
`define CSMV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csmv assertion failed");

`endif

[rtl/core/csmv_pkg.sv]
// package with sizes, codes and pipeline types of the column sum / matvec block
package csmv_pkg;

  localparam int MAX_DIM        = 64;
  localparam int ELEMENT_BITS   = 16;
  localparam int ELEM_PORT_BITS = 16;
  localparam int SIZE_BITS      = 7;
  localparam int INDEX_BITS     = 6;
  localparam int VALUE_BITS     = 44;
  localparam int CFG_ADDR_BITS  = 3;
  localparam int CFG_DATA_BITS  = 32;

  localparam int DIM_BITS  = $clog2(MAX_DIM);
  localparam int SUM_BITS  = ELEMENT_BITS + DIM_BITS;
  localparam int PROD_BITS = SUM_BITS + ELEMENT_BITS;
  localparam int ACC_BITS  = PROD_BITS + DIM_BITS;

  // word address of the size register
  localparam logic REG_MATRIX_SIZE = 1'b0;

  typedef enum logic {
    MODE_A = 1'b0,
    MODE_B = 1'b1
  } mode_t;

  typedef enum logic {
    KIND_SUM  = 1'b0,
    KIND_PROD = 1'b1
  } kind_t;

  // one element as it leaves the sequencer
  typedef struct packed {
    mode_t                          mode;
    logic signed [ELEMENT_BITS-1:0] elem;
    logic [DIM_BITS-1:0]            col;
    logic                           first;   // first row for A, first column for B
    logic                           out_en;
    logic [INDEX_BITS-1:0]          out_idx;
    logic                           out_last;
  } elem_info_t;

  // accumulate stage contents
  typedef struct packed {
    mode_t                       mode;
    logic                        first;
    logic                        out_en;
    logic [INDEX_BITS-1:0]       out_idx;
    logic                        out_last;
    logic signed [PROD_BITS-1:0] val;
  } acc_info_t;

endpackage

[rtl/core/csmv_sum_ram.sv]
// column sum memory with registered read and write-to-read forwarding
module csmv_sum_ram (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    rd_en,
  input  logic [csmv_pkg::DIM_BITS-1:0]           rd_addr,
  input  logic                                    wr_en,
  input  logic [csmv_pkg::DIM_BITS-1:0]           wr_addr,
  input  logic signed [csmv_pkg::SUM_BITS-1:0]    wr_data,
  output logic signed [csmv_pkg::SUM_BITS-1:0]    rd_data
);
  import csmv_pkg::*;

  logic signed [SUM_BITS-1:0] mem [MAX_DIM];
  logic signed [SUM_BITS-1:0] q_r;
  logic signed [SUM_BITS-1:0] fwd_data_r;
  logic                       fwd_hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r        <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  // a read that meets a write to the same entry takes the new data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (rd_en) begin
      fwd_hit_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_hit_r ? fwd_data_r : q_r;

endmodule

[rtl/core/csmv_seq.sv]
// row and column counters of both matrices, element decode
module csmv_seq (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [csmv_pkg::SIZE_BITS-1:0]        size_reg,
  input  logic                                  accept,
  input  logic                                  mode,
  input  logic [csmv_pkg::ELEM_PORT_BITS-1:0]   element,
  output csmv_pkg::elem_info_t                  info
);
  import csmv_pkg::*;

  logic [DIM_BITS-1:0]  a_row_r, a_col_r, b_row_r, b_col_r;
  logic [DIM_BITS-1:0]  a_row_nxt, a_col_nxt, b_row_nxt, b_col_nxt;
  logic [SIZE_BITS-1:0] size_eff;
  logic [DIM_BITS-1:0]  end_idx;
  logic                 a_end_col, a_end_row, b_end_col, b_end_row;
  mode_t                mode_in;

  assign mode_in = mode_t'(mode);

  // zero acts as one, anything above the array depth as the depth
  always_comb begin
    priority if (size_reg == '0) begin
      size_eff = SIZE_BITS'(1);
    end else if (size_reg > SIZE_BITS'(MAX_DIM)) begin
      size_eff = SIZE_BITS'(MAX_DIM);
    end else begin
      size_eff = size_reg;
    end
  end

  assign end_idx   = DIM_BITS'(size_eff - SIZE_BITS'(1));
  assign a_end_col = a_col_r >= end_idx;
  assign a_end_row = a_row_r >= end_idx;
  assign b_end_col = b_col_r >= end_idx;
  assign b_end_row = b_row_r >= end_idx;

  always_comb begin
    a_row_nxt = a_row_r;
    a_col_nxt = a_col_r;
    b_row_nxt = b_row_r;
    b_col_nxt = b_col_r;
    unique case (mode_in)
      MODE_A: begin
        if (a_end_col) begin
          a_col_nxt = '0;
          a_row_nxt = a_end_row ? '0 : a_row_r + DIM_BITS'(1);
        end else begin
          a_col_nxt = a_col_r + DIM_BITS'(1);
        end
      end
      MODE_B: begin
        if (b_end_col) begin
          b_col_nxt = '0;
          b_row_nxt = b_end_row ? '0 : b_row_r + DIM_BITS'(1);
        end else begin
          b_col_nxt = b_col_r + DIM_BITS'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_row_r <= '0;
      a_col_r <= '0;
      b_row_r <= '0;
      b_col_r <= '0;
    end else if (accept) begin
      a_row_r <= a_row_nxt;
      a_col_r <= a_col_nxt;
      b_row_r <= b_row_nxt;
      b_col_r <= b_col_nxt;
    end
  end

  always_comb begin
    info.mode = mode_in;
    info.elem = ELEMENT_BITS'(element);
    if (mode_in == MODE_A) begin
      info.col      = a_col_r;
      info.first    = (a_row_r == '0);
      info.out_en   = a_end_row;
      info.out_idx  = INDEX_BITS'(a_col_r);
      info.out_last = a_end_col;
    end else begin
      info.col      = b_col_r;
      info.first    = (b_col_r == '0);
      info.out_en   = b_end_col;
      info.out_idx  = INDEX_BITS'(b_row_r);
      info.out_last = b_end_row;
    end
  end

endmodule

[rtl/core/column_sum_then_matvec.sv]
// top level: column sums of A, then product of B with the sum vector
//
//   channel | direction | handshake        | payload
//   in      | input     | in_valid/stall   | in_mode, in_element
//   out     | output    | out_valid/stall  | out_kind, out_index, out_value, out_last
//   cfg     | input     | apb-style write  | matrix_size at byte address 0
//
// one element per cycle sustained while out does not stall; a result passes through the
// stage 1 register with the sum read, the stage 2 register, then the output register
// the memory reads and writes in the same cycle and forwards a write to a read of the
// same column, so back-to-back updates of one column need no bubble
// reset clears counters, row accumulator and pipeline valids; the sum memory is not cleared
// an out stall holds stage 2 only while it carries a result; earlier stages back up behind it
`include "column_sum_then_matvec_assert.svh"

module column_sum_then_matvec (
  input  logic                                        clk,
  input  logic                                        rst_n,
  // input transactions
  input  logic                                        in_valid,
  output logic                                        in_stall,
  input  logic                                        in_mode,
  input  logic signed [csmv_pkg::ELEM_PORT_BITS-1:0]  in_element,
  // result transactions
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output logic                                        out_kind,
  output logic [csmv_pkg::INDEX_BITS-1:0]             out_index,
  output logic signed [csmv_pkg::VALUE_BITS-1:0]      out_value,
  output logic                                        out_last,
  // configuration port
  input  logic                                        cfg_psel,
  input  logic                                        cfg_penable,
  input  logic                                        cfg_pwrite,
  input  logic [csmv_pkg::CFG_ADDR_BITS-1:0]          cfg_paddr,
  input  logic [csmv_pkg::CFG_DATA_BITS-1:0]          cfg_pwdata,
  output logic [csmv_pkg::CFG_DATA_BITS-1:0]          cfg_prdata,
  output logic                                        cfg_pready
);
  import csmv_pkg::*;

  // configuration register
  logic [SIZE_BITS-1:0] size_r;
  logic                 cfg_wr;

  // pipeline control
  logic accept;
  logic out_free, s2_move, s2_free, s1_move, s1_free;

  // sequencer to stage 1
  elem_info_t s0_info;
  elem_info_t s1_r;
  logic       s1_v_r;

  // stage 2
  acc_info_t  s2_r, s2_nxt;
  logic       s2_v_r;

  // memory side
  logic                        mem_wr_en;
  logic signed [SUM_BITS-1:0]  mem_rd_data;
  logic signed [SUM_BITS-1:0]  sum_nxt;
  logic signed [SUM_BITS-1:0]  elem_ext;
  logic signed [PROD_BITS-1:0] prod_nxt;

  // row accumulator
  logic signed [ACC_BITS-1:0]  acc_r, acc_nxt;

  // output register
  logic                         out_valid_r;
  kind_t                        out_kind_r;
  logic [INDEX_BITS-1:0]        out_index_r;
  logic signed [VALUE_BITS-1:0] out_value_r;
  logic                         out_last_r;
  logic signed [VALUE_BITS-1:0] value_nxt;

  // ---------------- configuration ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_BITS'(MAX_DIM);
    end else if (cfg_wr && (cfg_paddr[CFG_ADDR_BITS-1] == REG_MATRIX_SIZE)) begin
      size_r <= cfg_pwdata[SIZE_BITS-1:0];
    end
  end

  // low address bits are not decoded and do not change the register
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_BITS-1] == REG_MATRIX_SIZE)
                    ? CFG_DATA_BITS'(size_r) : '0;

  // ---------------- flow control ----------------
  // a stage moves when the one after it is empty or moving as well;
  // a stage whose transaction makes no result never waits on out
  assign out_free = !out_valid_r || !out_stall;
  assign s2_move  = s2_v_r && (!s2_r.out_en || out_free);
  assign s2_free  = !s2_v_r || s2_move;
  assign s1_move  = s1_v_r && s2_free;
  assign s1_free  = !s1_v_r || s1_move;
  assign in_stall = !s1_free;
  assign accept   = in_valid && s1_free;

  // ---------------- stage 0: counters, memory read issue ----------------
  csmv_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .size_reg (size_r),
    .accept   (accept),
    .mode     (in_mode),
    .element  (in_element),
    .info     (s0_info)
  );

  csmv_sum_ram u_sum_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (s0_info.col),
    .wr_en   (mem_wr_en),
    .wr_addr (s1_r.col),
    .wr_data (sum_nxt),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_move) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s0_info;
    end
  end

  // ---------------- stage 1: column sum update or multiply ----------------
  assign elem_ext = SUM_BITS'(s1_r.elem);
  // first row of A starts the column over, later rows add to it
  assign sum_nxt  = s1_r.first ? elem_ext : mem_rd_data + elem_ext;
  // B element times the column sum at its position
  assign prod_nxt = mem_rd_data * s1_r.elem;
  assign mem_wr_en = s1_move && (s1_r.mode == MODE_A);

  always_comb begin
    s2_nxt.mode     = s1_r.mode;
    s2_nxt.first    = s1_r.first;
    s2_nxt.out_en   = s1_r.out_en;
    s2_nxt.out_idx  = s1_r.out_idx;
    s2_nxt.out_last = s1_r.out_last;
    s2_nxt.val      = (s1_r.mode == MODE_A) ? PROD_BITS'(sum_nxt) : prod_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s1_move) begin
      s2_v_r <= 1'b1;
    end else if (s2_move) begin
      s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_r <= s2_nxt;
    end
  end

  // ---------------- stage 2: row accumulate, result select ----------------
  // first column of a B row starts the dot product from zero
  assign acc_nxt   = (s2_r.first ? '0 : acc_r) + ACC_BITS'(s2_r.val);
  assign value_nxt = (s2_r.mode == MODE_A) ? VALUE_BITS'(s2_r.val) : VALUE_BITS'(acc_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (s2_move && (s2_r.mode == MODE_B)) begin
      acc_r <= acc_nxt;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_move && s2_r.out_en) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move && s2_r.out_en) begin
      out_kind_r  <= (s2_r.mode == MODE_A) ? KIND_SUM : KIND_PROD;
      out_index_r <= s2_r.out_idx;
      out_value_r <= value_nxt;
      out_last_r  <= s2_r.out_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_index = out_index_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

  // ---------------- assertions ----------------
  // input backs up only behind an occupied stage 1
  `CSMV_ASSERT_IMP(a_stall_needs_busy_s1, in_stall, s1_v_r)
  // a result leaving stage 2 is on the output the next cycle
  `CSMV_ASSERT_NXT(a_result_reaches_out, s2_move && s2_r.out_en, out_valid_r)
  // a read that meets a write to the same column sees the written sum
  `CSMV_ASSERT_NXT(a_sum_forwarded, accept && mem_wr_en && (s0_info.col == s1_r.col), mem_rd_data == $past(sum_nxt))

endmodule

[test/column_sum_then_matvec_tb.sv]
// self-checking testbench for the column sum then matrix-vector product block
module column_sum_then_matvec_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import csmv_pkg::*;

  // margin after the queues empty, to cover any item still in flight
  localparam int DRAIN_CYCLES = 10;
  localparam int RANDOM_ITEMS = 760;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic signed [ELEM_PORT_BITS-1:0] ELEM_MAX = {1'b0, {(ELEM_PORT_BITS-1){1'b1}}};
  localparam logic signed [ELEM_PORT_BITS-1:0] ELEM_MIN = {1'b1, {(ELEM_PORT_BITS-1){1'b0}}};
  localparam logic [CFG_ADDR_BITS-1:0] SIZE_ADDR = CFG_ADDR_BITS'(4 * REG_MATRIX_SIZE);

  typedef struct {
    mode_t                             mode;
    logic signed [ELEM_PORT_BITS-1:0]  element;
  } element_txn_t;

  typedef struct {
    kind_t                         kind;
    logic [INDEX_BITS-1:0]         index;
    logic signed [VALUE_BITS-1:0]  value;
    logic                          last;
  } matvec_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic                               in_mode = 1'b0;
  logic signed [ELEM_PORT_BITS-1:0]   in_element = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic                               out_kind;
  logic [INDEX_BITS-1:0]              out_index;
  logic signed [VALUE_BITS-1:0]       out_value;
  logic                               out_last;
  logic                               cfg_psel = 1'b0;
  logic                               cfg_penable = 1'b0;
  logic                               cfg_pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0]           cfg_paddr = '0;
  logic [CFG_DATA_BITS-1:0]           cfg_pwdata = '0;
  logic [CFG_DATA_BITS-1:0]           cfg_prdata;
  logic                               cfg_pready;

  column_sum_then_matvec DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_mode     (in_mode),
    .in_element  (in_element),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_kind    (out_kind),
    .out_index   (out_index),
    .out_value   (out_value),
    .out_last    (out_last),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // transactions waiting for the driver, and results waiting for the monitor
  element_txn_t   element_queue[$];
  matvec_result_t result_queue[$];
  int             failures = 0;
  int             queued_items = 0;

  // predictor state, as it stands after reset
  logic [SIZE_BITS-1:0]          size_reg = SIZE_BITS'(MAX_DIM);
  logic signed [VALUE_BITS-1:0]  column_total[MAX_DIM] = '{default: '0};
  logic signed [VALUE_BITS-1:0]  row_acc = '0;
  int a_row = 0, a_col = 0, b_row = 0, b_col = 0;

  // position the generator expects each matrix to be at once its items are taken
  int gen_a_row = 0, gen_a_col = 0, gen_b_row = 0, gen_b_col = 0;

  // size in use: zero behaves as one, anything above the maximum as the maximum
  function automatic int active_size();
    if (size_reg == 0) return 1;
    if (size_reg > MAX_DIM) return MAX_DIM;
    return int'(size_reg);
  endfunction

  // row-major walk; a counter at or past the end of its range wraps
  function automatic void step_pos(inout int row, inout int col, input int n);
    if (col >= n - 1) begin
      col = 0;
      row = (row >= n - 1) ? 0 : row + 1;
    end else begin
      col = col + 1;
    end
  endfunction

  // one accepted element: update sums or row product, queue the result it causes
  function automatic void apply_element(mode_t mode, logic signed [ELEM_PORT_BITS-1:0] raw);
    int n;
    int col;
    bit end_col;
    bit end_row;
    logic signed [ELEMENT_BITS-1:0] narrow;
    logic signed [VALUE_BITS-1:0]   e;
    logic signed [VALUE_BITS-1:0]   acc;
    matvec_result_t r;
    n = active_size();
    narrow = raw[ELEMENT_BITS-1:0];
    e = narrow;
    if (mode == MODE_A) begin
      col = (a_col < MAX_DIM) ? a_col : MAX_DIM - 1;
      end_col = a_col >= n - 1;
      end_row = a_row >= n - 1;
      // first row restarts the column, every other row adds into it
      column_total[col] = (a_row == 0) ? e : column_total[col] + e;
      if (end_row) begin
        r.kind = KIND_SUM;
        r.index = INDEX_BITS'(col);
        r.value = column_total[col];
        r.last = end_col;
        result_queue.push_back(r);
      end
      step_pos(a_row, a_col, n);
    end else begin
      col = (b_col < MAX_DIM) ? b_col : MAX_DIM - 1;
      end_col = b_col >= n - 1;
      end_row = b_row >= n - 1;
      acc = (b_col == 0) ? '0 : row_acc;
      acc += column_total[col] * e;
      if (end_col) begin
        r.kind = KIND_PROD;
        r.index = INDEX_BITS'(b_row);
        r.value = acc;
        r.last = end_row;
        result_queue.push_back(r);
        row_acc = '0;
      end else begin
        row_acc = acc;
      end
      step_pos(b_row, b_col, n);
    end
  endfunction

  // idle cycles before the next transaction; occasionally switch to back-to-back
  function automatic int draw_gap(inout bit burst);
    if ($urandom_range(0, 31) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic logic signed [ELEM_PORT_BITS-1:0] rand_element();
    case ($urandom_range(0, 9))
      0: return ELEM_MAX;
      1: return ELEM_MIN;
      2: return '0;
      default: return ELEM_PORT_BITS'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents queued elements, holds the payload while stalled
  // ---------------------------------------------------------------------------
  element_txn_t next_txn;
  int           in_hold = 0;
  bit           in_burst = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_hold = 0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_element(mode_t'(in_mode), in_element);
        in_hold = draw_gap(in_burst);
      end
      // the channel is free for a new transaction at the next edge
      if (!in_valid || !in_stall) begin
        if (in_hold > 0) begin
          in_hold--;
          in_valid <= 1'b0;
        end else if (element_queue.size() > 0) begin
          next_txn = element_queue.pop_front();
          in_valid <= 1'b1;
          in_mode <= next_txn.mode;
          in_element <= next_txn.element;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: stalls at random, checks each result against the oldest prediction
  // ---------------------------------------------------------------------------
  matvec_result_t awaited;
  int             out_hold = 0;
  bit             out_burst = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold = 0;
    end else if (out_valid && !out_stall) begin
      if (result_queue.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind %0d index %0d value %0d last %0d",
                 $time, out_kind, out_index, out_value, out_last);
        failures++;
      end else begin
        awaited = result_queue.pop_front();
        if (out_kind !== awaited.kind) begin
          $display("%0t: kind mismatch, expected %0d, got %0d", $time, awaited.kind, out_kind);
          failures++;
        end
        if (out_index !== awaited.index) begin
          $display("%0t: index mismatch, expected %0d, got %0d", $time, awaited.index, out_index);
          failures++;
        end
        if (out_value !== awaited.value) begin
          $display("%0t: value mismatch, expected %0d, got %0d", $time, awaited.value, out_value);
          failures++;
        end
        if (out_last !== awaited.last) begin
          $display("%0t: last mismatch, expected %0d, got %0d", $time, awaited.last, out_last);
          failures++;
        end
      end
      out_hold = draw_gap(out_burst);
      out_stall <= (out_hold > 0);
    end else if (out_hold > 0) begin
      out_hold--;
      out_stall <= (out_hold > 0);
    end
  end

  // watchdog
  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_item(input mode_t mode, input logic signed [ELEM_PORT_BITS-1:0] value);
    element_txn_t t;
    t.mode = mode;
    t.element = value;
    element_queue.push_back(t);
    queued_items++;
    if (mode == MODE_A) step_pos(gen_a_row, gen_a_col, active_size());
    else step_pos(gen_b_row, gen_b_col, active_size());
  endtask

  // random elements until the matrix wraps back to its first position;
  // from the start this is a whole matrix, from the middle it finishes the current one
  task automatic queue_matrix(input mode_t mode);
    do begin
      queue_item(mode, rand_element());
    end while (mode == MODE_A ? (gen_a_row != 0 || gen_a_col != 0)
                              : (gen_b_row != 0 || gen_b_col != 0));
  endtask

  // wait until every transaction is taken and every result has come back
  task automatic settle();
    do @(negedge clk);
    while (element_queue.size() != 0 || in_valid || result_queue.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(input logic write, input logic [CFG_DATA_BITS-1:0] wdata,
                            output logic [CFG_DATA_BITS-1:0] rdata);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= write;
    cfg_paddr <= SIZE_ADDR;
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk);
    while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // size change only once the block is idle; read back what was written
  task automatic set_size(input int unsigned value);
    logic [CFG_DATA_BITS-1:0] rd;
    settle();
    cfg_access(1'b1, CFG_DATA_BITS'(value), rd);
    size_reg = SIZE_BITS'(value);
    cfg_access(1'b0, '0, rd);
    if (rd !== CFG_DATA_BITS'(size_reg)) begin
      $display("%0t: matrix_size readback mismatch, expected %0d, got %0d",
               $time, size_reg, rd);
      failures++;
    end
    gen_a_row = a_row;
    gen_a_col = a_col;
    gen_b_row = b_row;
    gen_b_col = b_col;
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int pick;
    int reps;
    int start_count;
    int unsigned sz;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // first row of A at full size: every column sum gets written before any read of it is used
    repeat (MAX_DIM) queue_item(MODE_A, rand_element());

    // size one; the A row counter is already past the end, so this closes column 0
    set_size(1);
    queue_item(MODE_A, ELEM_MAX);
    // size one proper: one element starts and completes its column
    queue_item(MODE_A, ELEM_MIN);
    queue_item(MODE_B, ELEM_MIN);
    queue_item(MODE_B, ELEM_MAX);

    // zero behaves as size one
    set_size(0);
    queue_item(MODE_A, '0);
    queue_item(MODE_B, ELEM_MAX);

    // size two with A and B interleaved, extreme and alternating bit patterns
    set_size(2);
    queue_item(MODE_A, ELEM_MAX);
    queue_item(MODE_B, ELEM_MIN);
    queue_item(MODE_A, ELEM_MIN);
    queue_item(MODE_B, ELEM_MAX);
    queue_item(MODE_A, 16'sh5555);
    queue_item(MODE_B, 16'shAAAA);
    queue_item(MODE_A, 16'shAAAA);
    queue_item(MODE_B, 16'sh5555);

    // oversize clamps to the maximum; leave both matrices mid-row
    set_size(127);
    repeat (3) queue_item(MODE_A, rand_element());
    repeat (3) queue_item(MODE_B, rand_element());

    // shrink under the counters: both wrap on their next element
    set_size(3);
    queue_item(MODE_A, ELEM_MIN);
    queue_item(MODE_B, ELEM_MAX);

    // random phases: mostly whole A then B matrices at small sizes, some noise
    start_count = queued_items;
    while (queued_items - start_count < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) sz = 0;
      else if (pick < 10) sz = $urandom_range(MAX_DIM + 1, 127);
      else if (pick < 14) sz = MAX_DIM;
      else if (pick < 24) sz = $urandom_range(7, 10);
      else sz = $urandom_range(1, 6);
      set_size(sz);
      if (active_size() <= 10 && $urandom_range(0, 3) != 0) begin
        reps = (active_size() <= 4) ? $urandom_range(1, 3) : 1;
        repeat (reps) begin
          queue_matrix(MODE_A);
          queue_matrix(MODE_B);
        end
      end else begin
        repeat ($urandom_range(5, 40))
          queue_item(mode_t'($urandom_range(0, 1)), rand_element());
      end
    end

    settle();
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/csmv_pkg.sv
rtl/core/csmv_sum_ram.sv
rtl/core/csmv_seq.sv
rtl/core/column_sum_then_matvec.sv
test/column_sum_then_matvec_tb.sv
